// ----- rtl/assert_macros.svh -----
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- rtl/alle_pkg.sv -----
package alle_pkg;

    localparam int SLOTS       = 16;
    localparam int IDX_W       = $clog2(SLOTS);
    localparam int LINK_W      = $clog2(SLOTS + 1);
    localparam int MAX_RESULTS = 16;
    localparam int WALK_MAX    = (SLOTS < MAX_RESULTS) ? SLOTS : MAX_RESULTS;
    localparam int CNT_W       = $clog2(SLOTS);
    localparam int VAL_W       = 32;
    localparam int CMD_W       = 2;
    localparam int ST_W        = 3;
    localparam int SLOT_W      = 4;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WALK   = 2'd2;

    localparam logic [ST_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
    localparam logic [ST_W-1:0] ST_DELETED  = 3'd2;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd4;
    localparam logic [ST_W-1:0] ST_ELEMENT  = 3'd5;

    localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(SLOTS);

    typedef logic [IDX_W-1:0]        t_idx;
    typedef logic [LINK_W-1:0]       t_link;
    typedef logic signed [VAL_W-1:0] t_val;

    // One result beat from the sequencer toward the output register.
    typedef struct packed {
        logic              valid;
        logic [ST_W-1:0]   status;
        t_val              value;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } t_emit;

    // Requests into the node memory.
    typedef struct packed {
        logic  rd_en;
        t_idx  rd_addr;
        logic  val_we;
        t_idx  val_addr;
        t_val  val_data;
        logic  lnk_we;
        t_idx  lnk_addr;
        t_link lnk_data;
    } t_ram_req;

    typedef struct packed {
        t_val  value;
        t_link link;
    } t_ram_rsp;

    // Lowest slot whose used bit is clear; only meaningful when one exists.
    function automatic t_idx first_free(input logic [SLOTS-1:0] used);
        t_idx idx;
        idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!used[i]) begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

    // Slot index as shown on the result, zero extended or cut to four bits.
    function automatic logic [SLOT_W-1:0] to_slot(input t_idx idx);
        logic [IDX_W+SLOT_W-1:0] ext;
        ext = {{SLOT_W{1'b0}}, idx};
        return ext[SLOT_W-1:0];
    endfunction

endpackage

// ----- rtl/alle_node_ram.sv -----
module alle_node_ram (
    input  logic              i_clk,
    input  alle_pkg::t_ram_req i_req,
    output alle_pkg::t_ram_rsp o_rsp
);
    import alle_pkg::*;

    t_val  r_values [SLOTS];
    t_link r_links  [SLOTS];
    t_ram_rsp r_rsp;

    always_ff @(posedge i_clk) begin
        if (i_req.val_we) begin
            r_values[i_req.val_addr] <= i_req.val_data;
        end
        if (i_req.lnk_we) begin
            r_links[i_req.lnk_addr] <= i_req.lnk_data;
        end
        if (i_req.rd_en) begin
            r_rsp.value <= r_values[i_req.rd_addr];
            r_rsp.link  <= r_links[i_req.rd_addr];
        end
    end

    assign o_rsp = r_rsp;

endmodule

// ----- rtl/alle_seq.sv -----
module alle_seq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [alle_pkg::CMD_W-1:0] i_cmd,
    input  alle_pkg::t_val             i_value,
    output logic                       o_ready,
    input  logic                       i_out_free,
    output alle_pkg::t_emit            o_emit,
    output alle_pkg::t_ram_req         o_ram_req,
    input  alle_pkg::t_ram_rsp         i_ram_rsp
);
    import alle_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_INS_LINK = 3'd1;
    localparam logic [2:0] S_DEL      = 3'd2;
    localparam logic [2:0] S_WALK     = 3'd3;
    localparam logic [2:0] S_RESP     = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [SLOTS-1:0] r_used, n_used;
    t_link            r_head, n_head;
    t_link            r_tail, n_tail;
    t_link            r_cur, n_cur;
    t_link            r_prev, n_prev;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [ST_W-1:0]  r_status, n_status;
    t_val             r_val, n_val;
    t_idx             r_slot, n_slot;

    t_idx     free_idx;
    t_idx     cur_idx;
    logic     list_full;
    logic     next_none;
    logic     walk_last;
    t_ram_req req;
    t_emit    emit;

    assign free_idx  = first_free(r_used);
    assign list_full = &r_used;
    assign cur_idx   = r_cur[IDX_W-1:0];
    assign next_none = (i_ram_rsp.link == LINK_NONE);
    assign walk_last = next_none || (r_cnt == CNT_W'(WALK_MAX - 1));

    always_comb begin
        n_state  = r_state;
        n_used   = r_used;
        n_head   = r_head;
        n_tail   = r_tail;
        n_cur    = r_cur;
        n_prev   = r_prev;
        n_cnt    = r_cnt;
        n_status = r_status;
        n_val    = r_val;
        n_slot   = r_slot;
        req      = '0;
        emit     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    unique case (i_cmd)
                        CMD_INSERT: begin
                            if (list_full) begin
                                n_status = ST_FULL;
                                n_val    = '0;
                                n_slot   = '0;
                                n_state  = S_RESP;
                            end else begin
                                req.val_we   = 1'b1;
                                req.val_addr = free_idx;
                                req.val_data = i_value;
                                req.lnk_we   = 1'b1;
                                req.lnk_addr = free_idx;
                                req.lnk_data = LINK_NONE;
                                n_used[free_idx] = 1'b1;
                                n_status = ST_INSERTED;
                                n_val    = i_value;
                                n_slot   = free_idx;
                                if (r_head == LINK_NONE) begin
                                    n_head  = LINK_W'(free_idx);
                                    n_tail  = LINK_W'(free_idx);
                                    n_state = S_RESP;
                                end else begin
                                    n_state = S_INS_LINK;
                                end
                            end
                        end
                        CMD_DELETE, CMD_WALK: begin
                            if (r_head == LINK_NONE) begin
                                n_status = ST_EMPTY;
                                n_val    = '0;
                                n_slot   = '0;
                                n_state  = S_RESP;
                            end else begin
                                req.rd_en   = 1'b1;
                                req.rd_addr = r_head[IDX_W-1:0];
                                n_cur   = r_head;
                                n_prev  = LINK_NONE;
                                n_cnt   = '0;
                                n_val   = i_value;
                                n_state = (i_cmd == CMD_WALK) ? S_WALK : S_DEL;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_INS_LINK: begin
                req.lnk_we   = 1'b1;
                req.lnk_addr = r_tail[IDX_W-1:0];
                req.lnk_data = LINK_W'(r_slot);
                n_tail  = LINK_W'(r_slot);
                n_state = S_RESP;
            end
            S_DEL: begin
                if (i_ram_rsp.value == r_val) begin
                    if (r_prev == LINK_NONE) begin
                        n_head = i_ram_rsp.link;
                    end else begin
                        req.lnk_we   = 1'b1;
                        req.lnk_addr = r_prev[IDX_W-1:0];
                        req.lnk_data = i_ram_rsp.link;
                    end
                    if (r_tail == r_cur) begin
                        n_tail = r_prev;
                    end
                    n_used[cur_idx] = 1'b0;
                    n_status = ST_DELETED;
                    n_slot   = cur_idx;
                    n_state  = S_RESP;
                end else if (next_none || (r_cnt == CNT_W'(SLOTS - 1))) begin
                    n_status = ST_NOTFOUND;
                    n_val    = '0;
                    n_slot   = '0;
                    n_state  = S_RESP;
                end else begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = i_ram_rsp.link[IDX_W-1:0];
                    n_prev = r_cur;
                    n_cur  = i_ram_rsp.link;
                    n_cnt  = r_cnt + CNT_W'(1);
                end
            end
            S_WALK: begin
                if (i_out_free) begin
                    emit.valid  = 1'b1;
                    emit.status = ST_ELEMENT;
                    emit.value  = i_ram_rsp.value;
                    emit.slot   = to_slot(cur_idx);
                    emit.last   = walk_last;
                    if (walk_last) begin
                        n_state = S_IDLE;
                    end else begin
                        req.rd_en   = 1'b1;
                        req.rd_addr = i_ram_rsp.link[IDX_W-1:0];
                        n_cur = i_ram_rsp.link;
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                end
            end
            S_RESP: begin
                if (i_out_free) begin
                    emit.valid  = 1'b1;
                    emit.status = r_status;
                    emit.value  = r_val;
                    emit.slot   = to_slot(r_slot);
                    emit.last   = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_head  <= LINK_NONE;
            r_tail  <= LINK_NONE;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_head  <= n_head;
            r_tail  <= n_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur    <= n_cur;
        r_prev   <= n_prev;
        r_cnt    <= n_cnt;
        r_status <= n_status;
        r_val    <= n_val;
        r_slot   <= n_slot;
    end

    assign o_ready   = (r_state == S_IDLE);
    assign o_emit    = emit;
    assign o_ram_req = req;

endmodule

// ----- rtl/array_linked_list_engine.sv -----
// Each command is taken in the idle state. Insert writes the new node, then its tail link when
// the list was not empty; delete reads from the head and compares node by node until a match or
// the end; walk passes one element per node to the output register. Full and empty lists answer
// with a status alone. One command at a time; a new command is taken the cycle after its last
// result enters the output register.
// Reset (synchronous, active low) empties the list and drops any pending result.
module array_linked_list_engine (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [alle_pkg::CMD_W-1:0] i_cmd,
    input  alle_pkg::t_val             i_value,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [alle_pkg::ST_W-1:0]  o_status,
    output alle_pkg::t_val             o_item_value,
    output logic [alle_pkg::SLOT_W-1:0] o_slot,
    output logic                       o_last
);
    import alle_pkg::*;

    // The list lives in a node memory (value and next link per slot) with a registered
    // read port. The sequencer keeps the used bits, head and tail pointers, and follows
    // links one node per cycle unless a walk waits on the output: the link read out addresses the next read.
    // A tail pointer lets insert link the new node without a search from the head.

    t_emit    emit;
    t_ram_req ram_req;
    t_ram_rsp ram_rsp;
    logic     out_free;

    logic              r_o_valid;
    logic [ST_W-1:0]   r_status;
    t_val              r_item_value;
    logic [SLOT_W-1:0] r_slot;
    logic              r_last;

    // The output register takes a new beat when it is empty or its beat is being taken.
    assign out_free = !r_o_valid || i_ready;

    alle_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_cmd      (i_cmd),
        .i_value    (i_value),
        .o_ready    (o_ready),
        .i_out_free (out_free),
        .o_emit     (emit),
        .o_ram_req  (ram_req),
        .i_ram_rsp  (ram_rsp)
    );

    alle_node_ram u_ram (
        .i_clk (i_clk),
        .i_req (ram_req),
        .o_rsp (ram_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (emit.valid) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    // Payload of the output register; only loaded together with a valid beat.
    always_ff @(posedge i_clk) begin
        if (emit.valid) begin
            r_status     <= emit.status;
            r_item_value <= emit.value;
            r_slot       <= emit.slot;
            r_last       <= emit.last;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_status     = r_status;
    assign o_item_value = r_item_value;
    assign o_slot       = r_slot;
    assign o_last       = r_last;

endmodule

// ----- rtl/alle_checker.sv -----
`include "assert_macros.svh"

module alle_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_ready,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic [alle_pkg::ST_W-1:0]   o_status,
    input alle_pkg::t_val              o_item_value,
    input logic [alle_pkg::SLOT_W-1:0] o_slot,
    input logic                        o_last
);
    import alle_pkg::*;

    logic no_data;
    logic zero_payload;

    // Statuses that carry neither a value nor a slot.
    assign no_data      = (o_status == ST_FULL) || (o_status == ST_NOTFOUND) ||
                          (o_status == ST_EMPTY);
    assign zero_payload = (o_item_value == '0) && (o_slot == '0);

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_status))
    `ASSERT_IMPL(a_single_last, i_clk, i_rst_n, o_valid && (o_status != ST_ELEMENT), o_last)
    `ASSERT_IMPL(a_no_payload, i_clk, i_rst_n, o_valid && no_data, zero_payload)
    `ASSERT_IMPL(a_busy_mid_walk, i_clk, i_rst_n, o_valid && !o_last, !o_ready)

endmodule

bind array_linked_list_engine alle_checker u_alle_checker (.*);

// ----- test/linked_list_checker.sv -----
`timescale 1ns / 100ps

module linked_list_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cmd_valid,
    input  logic                        i_cmd_ready,
    input  logic [alle_pkg::CMD_W-1:0]  i_cmd,
    input  alle_pkg::t_val              i_value,
    input  logic                        i_res_valid,
    input  logic                        i_res_ready,
    input  logic [alle_pkg::ST_W-1:0]   i_status,
    input  alle_pkg::t_val              i_item_value,
    input  logic [alle_pkg::SLOT_W-1:0] i_slot,
    input  logic                        i_last,
    output int                          o_errors,
    output int                          o_pending
);
    import alle_pkg::*;

    typedef struct {
        logic [ST_W-1:0]   status;
        t_val              value;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } t_list_result;

    t_list_result awaited_results[$];

    // Shadow copy of the list held in the slot array.
    t_val  node_value [SLOTS];
    t_link node_link  [SLOTS];
    logic  slot_taken [SLOTS];
    t_link head;
    int    errors = 0;

    task automatic push_result(input logic [ST_W-1:0] status, input t_val value,
                               input int idx, input logic last);
        t_list_result r;
        r.status = status;
        r.value  = value;
        r.slot   = idx[SLOT_W-1:0];
        r.last   = last;
        awaited_results.push_back(r);
    endtask

    task automatic predict_insert(input t_val val);
        int    free_idx;
        t_idx  new_idx;
        t_link cur;
        free_idx = SLOTS;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!slot_taken[i]) begin
                free_idx = i;
            end
        end
        if (free_idx == SLOTS) begin
            push_result(ST_FULL, '0, 0, 1'b1);
            return;
        end
        new_idx = IDX_W'(free_idx);
        node_value[new_idx] = val;
        node_link[new_idx]  = LINK_NONE;
        slot_taken[new_idx] = 1'b1;
        if (head == LINK_NONE) begin
            head = t_link'(new_idx);
        end else begin
            cur = head;
            for (int s = 0; s < SLOTS; s++) begin
                if (node_link[cur[IDX_W-1:0]] >= SLOTS) begin
                    break;
                end
                cur = node_link[cur[IDX_W-1:0]];
            end
            node_link[cur[IDX_W-1:0]] = t_link'(new_idx);
        end
        push_result(ST_INSERTED, val, free_idx, 1'b1);
    endtask

    task automatic predict_delete(input t_val val);
        t_link cur;
        t_link prev;
        if (head == LINK_NONE) begin
            push_result(ST_EMPTY, '0, 0, 1'b1);
            return;
        end
        cur  = head;
        prev = LINK_NONE;
        for (int s = 0; s < SLOTS && cur < SLOTS; s++) begin
            if (node_value[cur[IDX_W-1:0]] == val) begin
                if (prev == LINK_NONE) begin
                    head = node_link[cur[IDX_W-1:0]];
                end else begin
                    node_link[prev[IDX_W-1:0]] = node_link[cur[IDX_W-1:0]];
                end
                slot_taken[cur[IDX_W-1:0]] = 1'b0;
                node_link[cur[IDX_W-1:0]]  = LINK_NONE;
                push_result(ST_DELETED, val, int'(cur), 1'b1);
                return;
            end
            prev = cur;
            cur  = node_link[cur[IDX_W-1:0]];
        end
        push_result(ST_NOTFOUND, '0, 0, 1'b1);
    endtask

    task automatic predict_walk();
        t_link cur;
        logic  stop;
        if (head == LINK_NONE) begin
            push_result(ST_EMPTY, '0, 0, 1'b1);
            return;
        end
        cur = head;
        for (int s = 0; s < SLOTS && s < MAX_RESULTS; s++) begin
            stop = (node_link[cur[IDX_W-1:0]] >= SLOTS) || (s == SLOTS - 1) ||
                   (s == MAX_RESULTS - 1);
            push_result(ST_ELEMENT, node_value[cur[IDX_W-1:0]], int'(cur), stop);
            if (stop) begin
                break;
            end
            cur = node_link[cur[IDX_W-1:0]];
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_list_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                slot_taken[i] = 1'b0;
            end
            head = LINK_NONE;
            awaited_results.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (awaited_results.size() == 0) begin
                    errors++;
                    $display("%0t: result expected none actual status %0d value %0h slot %0d",
                             $time, i_status, i_item_value, i_slot);
                end else begin
                    want = awaited_results.pop_front();
                    check_field("status", 32'(want.status), 32'(i_status));
                    check_field("item_value", want.value, i_item_value);
                    check_field("slot", 32'(want.slot), 32'(i_slot));
                    check_field("last", 32'(want.last), 32'(i_last));
                end
            end
            if (i_cmd_valid && i_cmd_ready) begin
                case (i_cmd)
                    CMD_INSERT: predict_insert(i_value);
                    CMD_DELETE: predict_delete(i_value);
                    CMD_WALK:   predict_walk();
                    default:    ;
                endcase
            end
        end
        o_errors  <= errors;
        o_pending <= awaited_results.size();
    end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import alle_pkg::*;

    // Code 3 is not an operation; the block drops such a beat without a result.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_ITEMS = 450;
    // The tail of the run where neither side idles.
    localparam int QUIET_ITEMS  = 60;
    // Item count at which the receiver starts its long hold-off.
    localparam int HOLD_AT      = 120;
    localparam int HOLD_CYCLES  = 100;
    // Margin after the last result is taken, before the verdict.
    localparam int DRAIN_CYCLES = 40;
    // Watchdog limit on the cycle count of the whole run.
    localparam int CYCLE_LIMIT  = 500000;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic [CMD_W-1:0]  i_cmd   = CMD_INSERT;
    t_val              i_value = '0;
    logic              i_ready = 1'b0;

    logic              o_ready;
    logic              o_valid;
    logic [ST_W-1:0]   o_status;
    t_val              o_item_value;
    logic [SLOT_W-1:0] o_slot;
    logic              o_last;

    int fail_count;
    int pending_count;
    int cycle_count = 0;

    // Idling switches for the two sides, and the request for one long hold-off.
    bit sender_idles   = 1'b1;
    bit receiver_idles = 1'b1;
    bit hold_request   = 1'b0;

    // Values inserted recently, so that most deletes find a match.
    t_val inserted_pool[$];

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    array_linked_list_engine dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_cmd        (i_cmd),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_item_value (o_item_value),
        .o_slot       (o_slot),
        .o_last       (o_last)
    );

    linked_list_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (i_valid),
        .i_cmd_ready  (o_ready),
        .i_cmd        (i_cmd),
        .i_value      (i_value),
        .i_res_valid  (o_valid),
        .i_res_ready  (i_ready),
        .i_status     (o_status),
        .i_item_value (o_item_value),
        .i_slot       (o_slot),
        .i_last       (o_last),
        .o_errors     (fail_count),
        .o_pending    (pending_count)
    );

    // The watchdog ends a run that hangs, whatever the stimulus is doing.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("array_linked_list_engine: mismatch");
            $finish;
        end
    end

    // The receiver takes result beats, with short random stalls while idling is on,
    // and once a long hold-off so that the block backs up and drops its input ready.
    initial begin
        @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (receiver_idles && $urandom_range(0, 4) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Offers one command beat and returns at the edge that accepts it. Valid stays high
    // into the next beat unless a random gap is taken here.
    task automatic send_beat(input logic [CMD_W-1:0] cmd, input t_val val);
        i_valid <= 1'b1;
        i_cmd   <= cmd;
        i_value <= val;
        do @(posedge i_clk); while (!o_ready);
        if (cmd == CMD_INSERT) begin
            inserted_pool.push_back(val);
            if (inserted_pool.size() > 40) begin
                void'(inserted_pool.pop_front());
            end
        end
        if (sender_idles && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    // Corner values and a few small ones that repeat often, so that duplicates occur.
    function automatic t_val pick_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return -1;
            2:       return 32'h8000_0000;
            3:       return 32'h7fff_ffff;
            4, 5:    return t_val'($urandom_range(0, 7));
            default: return t_val'($urandom);
        endcase
    endfunction

    // A delete value: mostly one that was inserted, otherwise anything.
    function automatic t_val pick_victim();
        int idx;
        if (inserted_pool.size() != 0 && $urandom_range(0, 3) != 0) begin
            idx = $urandom_range(0, inserted_pool.size() - 1);
            return inserted_pool[idx];
        end
        return pick_value();
    endfunction

    initial begin
        int sent;
        int mode;
        int run_len;
        int pick;
        sent = 0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: empty list, extreme values, a duplicate, the three delete
        // positions, reuse of the lowest free slot, a full list and a full-length walk.
        send_beat(CMD_WALK, '0);
        send_beat(CMD_DELETE, 32'd5);
        send_beat(CMD_UNUSED, -1);
        send_beat(CMD_INSERT, '0);
        send_beat(CMD_INSERT, 32'h7fff_ffff);
        send_beat(CMD_INSERT, 32'h8000_0000);
        send_beat(CMD_INSERT, -1);
        send_beat(CMD_INSERT, '0);
        send_beat(CMD_DELETE, 32'h0000_1234);
        send_beat(CMD_WALK, -1);
        // The first zero is the head; the second zero stays at the tail.
        send_beat(CMD_DELETE, '0);
        send_beat(CMD_DELETE, -1);
        send_beat(CMD_DELETE, '0);
        send_beat(CMD_INSERT, 32'd42);
        send_beat(CMD_WALK, '0);
        // Three nodes are live; fill the rest and push one more into the full list.
        repeat (SLOTS - 3 + 1) begin
            send_beat(CMD_INSERT, t_val'($urandom));
        end
        send_beat(CMD_WALK, '0);

        // Random part, in runs that lean toward filling, draining or a mix, so that
        // the list keeps passing through empty, partly full and full.
        while (sent < RANDOM_ITEMS) begin
            mode    = $urandom_range(0, 2);
            run_len = $urandom_range(10, 30);
            repeat (run_len) begin
                if (sent == HOLD_AT) begin
                    hold_request = 1'b1;
                end
                if (sent == RANDOM_ITEMS - QUIET_ITEMS) begin
                    sender_idles   = 1'b0;
                    receiver_idles = 1'b0;
                end
                pick = $urandom_range(0, 99);
                if (pick < 2) begin
                    send_beat(CMD_UNUSED, t_val'($urandom));
                end else begin
                    pick = $urandom_range(0, 99);
                    if (pick < 12) begin
                        send_beat(CMD_WALK, t_val'($urandom));
                    end else if ((mode == 0 && pick < 75) || (mode == 1 && pick < 30) ||
                                 (mode == 2 && pick < 55)) begin
                        send_beat(CMD_INSERT, pick_value());
                    end else begin
                        send_beat(CMD_DELETE, pick_victim());
                    end
                    sent++;
                end
            end
        end

        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending_count == 0) begin
            $display("array_linked_list_engine: match");
        end else begin
            $display("array_linked_list_engine: mismatch");
        end
        $finish;
    end

endmodule

// ----- array_linked_list_engine.f -----
+incdir+rtl
rtl/alle_pkg.sv
rtl/alle_node_ram.sv
rtl/alle_seq.sv
rtl/array_linked_list_engine.sv
rtl/alle_checker.sv
test/linked_list_checker.sv
test/testbench.sv
